/* rtl/tgcpg_pkg.sv */
// Shared constants, types and codes for the text/graphics cell pixel generator.
package tgcpg_pkg;

  localparam int GLYPH_BYTES = 2048;
  localparam int GLYPH_AW    = $clog2(GLYPH_BYTES);

  localparam logic [8:0] ATTR_MASK    = 9'h1F8;
  localparam logic [8:0] ATTR_PATTERN = 9'h0F8;
  localparam logic [7:0] MODE_MASK    = 8'hE7;
  localparam logic [7:0] TEXT_MASK    = 8'hC0;
  localparam logic [7:0] INVERT_MASK  = 8'hFF;

  localparam int MODE_HALF_BIT = 6;
  localparam int MODE_DOT_BIT  = 7;

  localparam logic [2:0] WHITE = 3'd7;

  typedef logic [2:0] color_t;
  typedef color_t [7:0] pixels_t;

  typedef enum logic {
    ACT_RENDER = 1'b0,
    ACT_LOAD   = 1'b1
  } action_t;

  // Cell fields held between the glyph RAM read and the result register
  typedef struct packed {
    logic       valid;
    logic [8:0] code;
    logic [4:0] row;
    logic       cursor;
  } cell_t;

endpackage

/* rtl/tgcpg_glyph_ram.sv */
// Glyph RAM: one write port and one registered read port.
module tgcpg_glyph_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [tgcpg_pkg::GLYPH_AW-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic                          rd_en,
  input  logic [tgcpg_pkg::GLYPH_AW-1:0] rd_addr,
  output logic [7:0]                    rd_data
);

  logic [7:0] mem [tgcpg_pkg::GLYPH_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tgcpg_cell_shader.sv */
// Cell shader: turns one cell code and its glyph byte into eight palette indices.
module tgcpg_cell_shader (
  input  logic [7:0]         mode,
  input  tgcpg_pkg::cell_t   stage,
  input  tgcpg_pkg::color_t  fg,
  input  logic [7:0]         glyph,
  output logic               attr,
  output tgcpg_pkg::color_t  fg_next,
  output tgcpg_pkg::pixels_t pixels
);

  tgcpg_pkg::color_t bg;
  logic              code_hi;
  logic              text;
  logic [7:0]        pattern;

  always_comb begin
    bg      = mode[2:0];
    code_hi = stage.code[8];
    text    = (mode & tgcpg_pkg::TEXT_MASK) == 8'h00;
    attr    = (stage.code & tgcpg_pkg::ATTR_MASK) == tgcpg_pkg::ATTR_PATTERN;
    // attribute cells set the colour before the cell is drawn
    fg_next = attr ? stage.code[2:0] : fg;

    if (code_hi && mode[tgcpg_pkg::MODE_DOT_BIT]) begin
      pattern = stage.code[7:0];
    end else begin
      pattern = glyph;
    end
    if (code_hi && text) begin
      pattern = pattern ^ tgcpg_pkg::INVERT_MASK;
    end

    for (int i = 0; i < 8; i++) begin
      if (stage.cursor) begin
        pixels[i] = tgcpg_pkg::WHITE;
      end else if (mode[tgcpg_pkg::MODE_HALF_BIT] && code_hi) begin
        pixels[i] = (i < 4) ? stage.code[6:4] : stage.code[2:0];
      end else if (stage.row[3] || attr) begin
        pixels[i] = bg;
      end else begin
        pixels[i] = pattern[7-i] ? fg_next : bg;
      end
    end
  end

endmodule

/* rtl/text_graphics_cell_pixel_generator.sv */
// Throughput: one transaction per cycle while no finished result is stalled;
// the glyph RAM read port is registered and forms the first stage, the result
// register the second.
// Load transactions write the glyph RAM and give no result.
// Reset (rst, synchronous): clears the pipeline, screen mode to 0 and the
// foreground colour to white; glyph RAM contents are undefined until loaded.
module text_graphics_cell_pixel_generator (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       action,
  input  logic [10:0] rom_address,
  input  logic [7:0] rom_byte,
  input  logic [8:0] char_code,
  input  logic [4:0] raster_row,
  input  logic       cursor_here,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output logic [2:0] pixel0,
  output logic [2:0] pixel1,
  output logic [2:0] pixel2,
  output logic [2:0] pixel3,
  output logic [2:0] pixel4,
  output logic [2:0] pixel5,
  output logic [2:0] pixel6,
  output logic [2:0] pixel7,
  input  logic       mode_valid,
  output logic       mode_ready,
  input  logic [7:0] screen_mode
);

  logic [7:0]         mode;
  tgcpg_pkg::color_t  fg;
  tgcpg_pkg::color_t  fg_next;
  tgcpg_pkg::cell_t   stage;
  tgcpg_pkg::pixels_t pixels_next;
  tgcpg_pkg::pixels_t pixels;
  logic               advance;
  logic               accept;
  logic               is_load;
  logic               attr;
  logic [7:0]         glyph;
  logic [tgcpg_pkg::GLYPH_AW-1:0] rd_addr;

  // hold the whole pipeline while a finished result is stalled
  assign advance    = !(pixel_valid && pixel_stall);
  assign item_stall = !advance;
  assign accept     = item_valid && advance;
  assign is_load    = tgcpg_pkg::action_t'(action) == tgcpg_pkg::ACT_LOAD;
  assign mode_ready = 1'b1;
  assign rd_addr    = {char_code[7:0], raster_row[2:0]};

  tgcpg_glyph_ram u_glyph_ram (
    .clk     (clk),
    .wr_en   (accept && is_load),
    .wr_addr (rom_address),
    .wr_data (rom_byte),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (glyph)
  );

  tgcpg_cell_shader u_cell_shader (
    .mode    (mode),
    .stage   (stage),
    .fg      (fg),
    .glyph   (glyph),
    .attr    (attr),
    .fg_next (fg_next),
    .pixels  (pixels_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 8'h00;
    end else if (mode_valid && mode_ready) begin
      mode <= screen_mode & tgcpg_pkg::MODE_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
      pixel_valid <= 1'b0;
      fg          <= tgcpg_pkg::WHITE;
    end else if (advance) begin
      stage.valid  <= accept && !is_load;
      stage.code   <= char_code;
      stage.row    <= raster_row;
      stage.cursor <= cursor_here;
      pixel_valid  <= stage.valid;
      if (stage.valid && attr) begin
        fg <= fg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixels <= pixels_next;
    end
  end

  assign pixel0 = pixels[0];
  assign pixel1 = pixels[1];
  assign pixel2 = pixels[2];
  assign pixel3 = pixels[3];
  assign pixel4 = pixels[4];
  assign pixel5 = pixels[5];
  assign pixel6 = pixels[6];
  assign pixel7 = pixels[7];

endmodule
